/* rtl/core/blu_pkg.sv */
// Shared types and constants for the banded LU solver.
`timescale 1ns / 1ps
package blu_pkg;

  localparam int unsigned MaxOrder = 16;

  localparam int unsigned RegMatrixSize = 0;
  localparam int unsigned RegBandWidth  = 1;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_DIV,
    OP_SUB,
    OP_ADD,
    OP_PASS
  } alu_op_e;

  // Command bundle from the controller to the datapath.
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_cmd_t;

  // Status bundle from the datapath to the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

/* rtl/core/blu_alu.sv */
// Shared fixed point arithmetic unit: saturating multiply, divide, add and subtract.
`timescale 1ns / 1ps
module blu_alu #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  blu_pkg::alu_cmd_t            cmd_i,
  input  logic signed [VALUE_BITS-1:0] a_i,
  input  logic signed [VALUE_BITS-1:0] b_i,
  output logic signed [VALUE_BITS-1:0] res_o,
  output blu_pkg::alu_sts_t            sts_o
);
  import blu_pkg::*;

  localparam int unsigned NumW  = VALUE_BITS + FRAC_BITS;
  localparam int unsigned CntW  = $clog2(NumW + 1);
  localparam int unsigned ProdW = 2 * VALUE_BITS;

  logic signed [VALUE_BITS-1:0] posmax, negmax;
  assign posmax = {1'b0, {(VALUE_BITS-1){1'b1}}};
  assign negmax = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [VALUE_BITS-1:0] mag_a, mag_b;
  assign mag_a = a_i[VALUE_BITS-1] ? VALUE_BITS'(-a_i) : VALUE_BITS'(a_i);
  assign mag_b = b_i[VALUE_BITS-1] ? VALUE_BITS'(-b_i) : VALUE_BITS'(b_i);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  alu_op_e               op_q, op_d;
  logic                  neg_q, neg_d;
  logic [NumW-1:0]       num_q, num_d;
  logic [VALUE_BITS-1:0] den_q, den_d;
  logic [VALUE_BITS:0]   rem_q, rem_d;
  logic [NumW-1:0]       quo_q, quo_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic signed [VALUE_BITS-1:0] res_q, res_d;

  logic [VALUE_BITS:0]   rem_sh;
  logic [ProdW-1:0]      prod_sh;
  logic signed [VALUE_BITS:0] sum_w;

  // Saturate a magnitude with sign into the value range.
  function automatic logic signed [VALUE_BITS-1:0] pack_mag(
    input logic neg, input logic [ProdW-1:0] m);
    logic [ProdW-1:0] lim;
    begin
      lim = ProdW'({1'b0, {(VALUE_BITS-1){1'b1}}});
      if (!neg) pack_mag = (m > lim) ? posmax : VALUE_BITS'(m);
      else if (m > lim + 1) pack_mag = negmax;
      else pack_mag = VALUE_BITS'(-m);
    end
  endfunction

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    neg_d  = neg_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    prod_d = prod_q;
    res_d  = res_q;
    rem_sh = {rem_q[VALUE_BITS-1:0], num_q[NumW-1]};
    prod_sh = prod_q >> FRAC_BITS;
    sum_w  = '0;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      neg_d  = a_i[VALUE_BITS-1] ^ b_i[VALUE_BITS-1];
      num_d  = {mag_a, {FRAC_BITS{1'b0}}};
      den_d  = mag_b;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(NumW);
      prod_d = ProdW'(mag_a) * ProdW'(mag_b);
      unique case (cmd_i.op)
        OP_ADD: sum_w = {a_i[VALUE_BITS-1], a_i} + {b_i[VALUE_BITS-1], b_i};
        OP_SUB: sum_w = {a_i[VALUE_BITS-1], a_i} - {b_i[VALUE_BITS-1], b_i};
        default: sum_w = {a_i[VALUE_BITS-1], a_i};
      endcase
      if (cmd_i.op == OP_ADD || cmd_i.op == OP_SUB || cmd_i.op == OP_PASS) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (sum_w[VALUE_BITS] != sum_w[VALUE_BITS-1])
          res_d = sum_w[VALUE_BITS] ? negmax : posmax;
        else res_d = sum_w[VALUE_BITS-1:0];
      end
    end else if (busy_q) begin
      unique case (op_q)
        OP_MUL: begin
          res_d  = pack_mag(neg_q, prod_sh);
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        OP_DIV: begin
          if (den_q == '0) begin
            res_d  = neg_q ? negmax : posmax;
            busy_d = 1'b0;
            done_d = 1'b1;
          end else if (cnt_q == '0) begin
            res_d  = pack_mag(neg_q, ProdW'(quo_q));
            busy_d = 1'b0;
            done_d = 1'b1;
          end else begin
            // one quotient bit per cycle
            num_d = num_q << 1;
            if (rem_sh >= {1'b0, den_q}) begin
              rem_d = rem_sh - {1'b0, den_q};
              quo_d = {quo_q[NumW-2:0], 1'b1};
            end else begin
              rem_d = rem_sh;
              quo_d = {quo_q[NumW-2:0], 1'b0};
            end
            cnt_d = cnt_q - 1'b1;
          end
        end
        default: begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    neg_q  <= neg_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign res_o      = res_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

/* rtl/core/blu_ctrl.sv */
// Sequencer for load, factorization, substitution and result output.
`timescale 1ns / 1ps
module blu_ctrl #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic                         in_func_i,
  input  logic [3:0]                   in_row_i,
  input  logic [3:0]                   in_col_i,
  input  logic signed [VALUE_BITS-1:0] in_val_i,
  input  logic                         in_done_i,
  input  logic [4:0]                   matrix_size_i,
  input  logic [4:0]                   band_width_i,
  input  logic                         cfg_wr_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [3:0]                   out_idx_o,
  output logic signed [VALUE_BITS-1:0] out_val_o,
  output logic                         out_stat_o,
  output logic                         out_last_o,
  output blu_pkg::alu_cmd_t            alu_cmd_o,
  output logic signed [VALUE_BITS-1:0] alu_a_o,
  output logic signed [VALUE_BITS-1:0] alu_b_o,
  input  logic signed [VALUE_BITS-1:0] alu_res_i,
  input  blu_pkg::alu_sts_t            alu_sts_i
);
  import blu_pkg::*;

  localparam int unsigned MAX_ORDER = MaxOrder;
  localparam int unsigned IW    = $clog2(MAX_ORDER);
  localparam int unsigned CW    = IW + 1;
  localparam int unsigned Depth = MAX_ORDER * MAX_ORDER;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PIV_RD, ST_PIV_CMP, ST_PIV_CHK, ST_SWP_RDK, ST_SWP_RDP, ST_SWP_WRK,
    ST_SWP_WRP, ST_RCP_RD, ST_RCP_WAIT, ST_L_RD, ST_L_WAIT, ST_U_RDK, ST_U_RDR,
    ST_U_MUL, ST_U_SUB, ST_FW_RD, ST_FW_MAC, ST_FW_ADD, ST_FW_FIN, ST_BK_RD, ST_BK_MAC,
    ST_BK_ADD, ST_BK_SUB, ST_BK_DIV, ST_OUT_RD, ST_OUT, ST_SING
  } state_e;

  logic signed [VALUE_BITS-1:0] mem_q [Depth];
  logic signed [VALUE_BITS-1:0] rhs_q [MAX_ORDER];
  logic signed [VALUE_BITS-1:0] wv_q  [MAX_ORDER];
  logic [IW-1:0]                ord_q [MAX_ORDER];

  state_e st_q;
  logic   fv_q, dirty_q;
  logic [CW-1:0] n_q, bw_q, end_q;
  logic [CW-1:0] k_q, r_q, c_q, piv_q;
  logic [VALUE_BITS-1:0] pmag_q;
  logic signed [VALUE_BITS-1:0] rd_q, t_q, acc_q, rcp_q, lrk_q;
  logic signed [VALUE_BITS-1:0] ov_q;
  logic [3:0] oidx_q;
  logic ost_q, olast_q, ovalid_q;

  logic          mwe;
  logic [2*IW-1:0] mwa, mra;
  logic signed [VALUE_BITS-1:0] mwd;
  logic          wwe;
  logic [IW-1:0] wwa;
  logic signed [VALUE_BITS-1:0] wwd;

  alu_cmd_t cmd;
  logic signed [VALUE_BITS-1:0] aa, ab;

  logic [CW-1:0] n_lim, bw_lim, k_end;
  logic [VALUE_BITS-1:0] rd_mag;
  logic in_acc;

  assign n_lim  = (matrix_size_i == '0) ? CW'(1) :
                  ({1'b0, matrix_size_i} > 6'(MAX_ORDER)) ? CW'(MAX_ORDER) : CW'(matrix_size_i);
  assign bw_lim = ({1'b0, band_width_i} > 6'(MAX_ORDER)) ? CW'(MAX_ORDER) : CW'(band_width_i);
  assign k_end  = ((CW+1)'(k_q) + (CW+1)'(bw_q) + 1'b1 < (CW+1)'(n_q)) ?
                  CW'(k_q + bw_q + 1'b1) : n_q;
  assign rd_mag = rd_q[VALUE_BITS-1] ? VALUE_BITS'(-rd_q) : VALUE_BITS'(rd_q);
  assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  function automatic logic [2*IW-1:0] adr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    adr = {r[IW-1:0], c[IW-1:0]};
  endfunction

  always_ff @(posedge clk_i) begin
    if (mwe) mem_q[mwa] <= mwd;
    rd_q <= mem_q[mra];
    if (wwe) wv_q[wwa] <= wwd;
    if (in_acc && in_func_i && (5'(in_row_i) < 5'(MAX_ORDER))) rhs_q[in_row_i[IW-1:0]] <= in_val_i;
  end

  // Memory and ALU port steering per state.
  always_comb begin
    mwe = 1'b0; mwa = '0; mwd = '0; mra = '0;
    wwe = 1'b0; wwa = '0; wwd = alu_res_i;
    cmd.start = 1'b0; cmd.op = OP_PASS; aa = '0; ab = '0;
    unique case (st_q)
      ST_IDLE: begin
        mwe = in_acc && !in_func_i && (5'(in_row_i) < 5'(MAX_ORDER))
              && (5'(in_col_i) < 5'(MAX_ORDER));
        mwa = {in_row_i[IW-1:0], in_col_i[IW-1:0]};
        mwd = in_val_i;
      end
      ST_PIV_RD:  mra = adr(r_q, k_q);
      ST_SWP_RDK: mra = adr(k_q, c_q);
      ST_SWP_RDP: mra = adr(piv_q, c_q);
      ST_SWP_WRK: begin mwe = 1'b1; mwa = adr(k_q, c_q); mwd = rd_q; end
      ST_SWP_WRP: begin mwe = 1'b1; mwa = adr(piv_q, c_q); mwd = t_q; end
      ST_RCP_RD:  mra = adr(k_q, k_q);
      ST_RCP_WAIT: if (!alu_sts_i.busy && !alu_sts_i.done) begin
        cmd.start = 1'b1; cmd.op = OP_DIV; aa = VALUE_BITS'(1) << FRAC_BITS; ab = rd_q;
      end
      ST_L_RD: mra = adr(r_q, k_q);
      ST_L_WAIT: begin
        if (!alu_sts_i.busy && !alu_sts_i.done) begin
          cmd.start = 1'b1; cmd.op = OP_MUL; aa = rcp_q; ab = rd_q;
        end
        if (alu_sts_i.done) begin mwe = 1'b1; mwa = adr(r_q, k_q); mwd = alu_res_i; end
      end
      ST_U_RDK: mra = adr(k_q, c_q);
      ST_U_RDR: mra = adr(r_q, c_q);
      ST_U_MUL: begin
        // hold the read of row r so the subtract sees it
        mra = adr(r_q, c_q);
        if (!alu_sts_i.busy && !alu_sts_i.done) begin
          cmd.start = 1'b1; cmd.op = OP_MUL; aa = lrk_q; ab = t_q;
        end else if (alu_sts_i.done) begin
          cmd.start = 1'b1; cmd.op = OP_SUB; aa = rd_q; ab = alu_res_i;
        end
      end
      ST_U_SUB: if (alu_sts_i.done) begin mwe = 1'b1; mwa = adr(r_q, c_q); mwd = alu_res_i; end
      ST_FW_RD, ST_BK_RD: mra = adr(r_q, c_q);
      ST_FW_MAC, ST_BK_MAC: if (!alu_sts_i.busy && !alu_sts_i.done) begin
        cmd.start = 1'b1; cmd.op = OP_MUL; aa = rd_q; ab = wv_q[c_q[IW-1:0]];
      end else if (alu_sts_i.done) begin
        cmd.start = 1'b1; cmd.op = OP_ADD; aa = acc_q; ab = alu_res_i;
      end
      ST_FW_FIN: if (!alu_sts_i.busy && !alu_sts_i.done) begin
        cmd.start = 1'b1; cmd.op = OP_SUB; aa = rhs_q[ord_q[r_q[IW-1:0]]]; ab = acc_q;
      end else if (alu_sts_i.done) begin wwe = 1'b1; wwa = r_q[IW-1:0]; end
      ST_BK_SUB: begin
        mra = adr(r_q, r_q);
        if (!alu_sts_i.busy && !alu_sts_i.done) begin
          cmd.start = 1'b1; cmd.op = OP_SUB; aa = wv_q[r_q[IW-1:0]]; ab = acc_q;
        end
      end
      ST_BK_DIV: if (!alu_sts_i.busy && !alu_sts_i.done) begin
        cmd.start = 1'b1; cmd.op = OP_DIV; aa = t_q; ab = rd_q;
      end else if (alu_sts_i.done) begin wwe = 1'b1; wwa = r_q[IW-1:0]; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; fv_q <= 1'b0; dirty_q <= 1'b0; ovalid_q <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) ord_q[i] <= IW'(i);
      n_q <= '0; bw_q <= '0; end_q <= '0; k_q <= '0; r_q <= '0; c_q <= '0; piv_q <= '0;
    end else begin
      if (cfg_wr_i) fv_q <= 1'b0;
      if (ovalid_q && m_axis_tready && st_q != ST_OUT_RD && st_q != ST_SING)
        ovalid_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (in_acc) begin
          if (!in_func_i) begin
            if ((5'(in_row_i) < 5'(MAX_ORDER)) && (5'(in_col_i) < 5'(MAX_ORDER)))
              dirty_q <= 1'b1;
          end else if (in_done_i) begin
            n_q <= n_lim; bw_q <= bw_lim;
            if (dirty_q) begin
              dirty_q <= 1'b0;
              for (int i = 0; i < MAX_ORDER; i++) ord_q[i] <= IW'(i);
              k_q <= '0; piv_q <= '0; end_q <= '0;
              // start pivot search of column 0
              r_q <= '0; st_q <= ST_PIV_RD; pmag_q <= '0;
            end else if (fv_q) begin
              r_q <= '0; c_q <= '0; acc_q <= '0; st_q <= ST_FW_RD;
            end else st_q <= ST_SING;
          end
        end
        ST_PIV_RD: begin
          if (r_q == k_q) begin end_q <= k_end; end
          st_q <= ST_PIV_CMP;
        end
        ST_PIV_CMP: begin
          if (r_q == k_q || rd_mag > pmag_q) begin piv_q <= r_q; pmag_q <= rd_mag; end
          if (r_q + 1'b1 < end_q) begin r_q <= r_q + 1'b1; st_q <= ST_PIV_RD; end
          else st_q <= ST_PIV_CHK;
        end
        ST_PIV_CHK: begin
          if (pmag_q == '0) begin fv_q <= 1'b0; st_q <= ST_SING; end
          else if (piv_q != k_q) begin
            ord_q[k_q[IW-1:0]] <= ord_q[piv_q[IW-1:0]];
            ord_q[piv_q[IW-1:0]] <= ord_q[k_q[IW-1:0]];
            c_q <= '0; st_q <= ST_SWP_RDK;
          end else st_q <= ST_RCP_RD;
        end
        ST_SWP_RDK: st_q <= ST_SWP_RDP;
        ST_SWP_RDP: begin t_q <= rd_q; st_q <= ST_SWP_WRK; end
        ST_SWP_WRK: st_q <= ST_SWP_WRP;
        ST_SWP_WRP: if (c_q + 1'b1 < n_q) begin c_q <= c_q + 1'b1; st_q <= ST_SWP_RDK; end
                    else st_q <= ST_RCP_RD;
        ST_RCP_RD: st_q <= ST_RCP_WAIT;
        ST_RCP_WAIT: if (alu_sts_i.done) begin
          rcp_q <= alu_res_i;
          if (k_q + 1'b1 < end_q) begin
            r_q <= k_q + 1'b1; st_q <= ST_L_RD;
          end else if (k_q + 1'b1 < n_q) begin
            k_q <= k_q + 1'b1; r_q <= k_q + 1'b1; pmag_q <= '0; st_q <= ST_PIV_RD;
          end else begin
            fv_q <= 1'b1; r_q <= '0; c_q <= '0; acc_q <= '0; st_q <= ST_FW_RD;
          end
        end
        ST_L_RD: st_q <= ST_L_WAIT;
        ST_L_WAIT: if (alu_sts_i.done) begin
          lrk_q <= alu_res_i; c_q <= k_q + 1'b1;
          st_q <= (k_q + 1'b1 < end_q) ? ST_U_RDK : ST_L_RD;
        end
        ST_U_RDK: st_q <= ST_U_RDR;
        ST_U_RDR: begin t_q <= rd_q; st_q <= ST_U_MUL; end
        ST_U_MUL: if (alu_sts_i.done) st_q <= ST_U_SUB;
        ST_U_SUB: if (alu_sts_i.done) begin
          if (c_q + 1'b1 < end_q) begin c_q <= c_q + 1'b1; st_q <= ST_U_RDK; end
          else if (r_q + 1'b1 < end_q) begin r_q <= r_q + 1'b1; st_q <= ST_L_RD; end
          else if (k_q + 1'b1 < n_q) begin
            k_q <= k_q + 1'b1; r_q <= k_q + 1'b1; pmag_q <= '0; st_q <= ST_PIV_RD;
          end else begin fv_q <= 1'b1; r_q <= '0; c_q <= '0; acc_q <= '0; st_q <= ST_FW_RD; end
        end
        ST_FW_RD: st_q <= (c_q < r_q) ? ST_FW_MAC : ST_FW_FIN;
        ST_FW_MAC: if (alu_sts_i.done) st_q <= ST_FW_ADD;
        ST_FW_ADD: if (alu_sts_i.done) begin
          acc_q <= alu_res_i; c_q <= c_q + 1'b1; st_q <= ST_FW_RD;
        end
        ST_FW_FIN: if (alu_sts_i.done) begin
          acc_q <= '0; c_q <= '0;
          if (r_q + 1'b1 < n_q) begin r_q <= r_q + 1'b1; st_q <= ST_FW_RD; end
          else begin r_q <= n_q - 1'b1; c_q <= n_q; st_q <= ST_BK_RD; end
        end
        ST_BK_RD: st_q <= (c_q < n_q && c_q != r_q) ? ST_BK_MAC : ST_BK_SUB;
        ST_BK_MAC: if (alu_sts_i.done) st_q <= ST_BK_ADD;
        ST_BK_ADD: if (alu_sts_i.done) begin
          acc_q <= alu_res_i; c_q <= c_q + 1'b1; st_q <= ST_BK_RD;
        end
        ST_BK_SUB: if (alu_sts_i.done) begin t_q <= alu_res_i; st_q <= ST_BK_DIV; end
        ST_BK_DIV: if (alu_sts_i.done) begin
          acc_q <= '0;
          if (r_q == '0) begin r_q <= '0; st_q <= ST_OUT_RD; end
          else begin r_q <= r_q - 1'b1; c_q <= r_q; st_q <= ST_BK_RD; end
        end
        ST_OUT_RD: if (!ovalid_q || m_axis_tready) begin
          ovalid_q <= 1'b1; oidx_q <= 4'(r_q); ov_q <= wv_q[r_q[IW-1:0]]; ost_q <= 1'b0;
          olast_q <= (r_q + 1'b1 == n_q);
          if (r_q + 1'b1 < n_q) r_q <= r_q + 1'b1; else st_q <= ST_IDLE;
        end
        ST_SING: if (!ovalid_q || m_axis_tready) begin
          ovalid_q <= 1'b1; oidx_q <= '0; ov_q <= '0; ost_q <= 1'b1; olast_q <= 1'b1;
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
      // back substitution: skip the diagonal term
      if (st_q == ST_BK_RD && c_q == r_q) c_q <= c_q + 1'b1;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign out_idx_o  = oidx_q;
  assign out_val_o  = ov_q;
  assign out_stat_o = ost_q;
  assign out_last_o = olast_q;
  assign alu_cmd_o  = cmd;
  assign alu_a_o    = aa;
  assign alu_b_o    = ab;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready) else $error("input taken while busy");
  a_sing_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ost_q) |-> olast_q) else $error("singular result not last");
  a_alu_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alu_cmd_o.start && alu_cmd_o.op == OP_DIV) |-> !alu_sts_i.busy)
    else $error("divide issued while busy");
`endif

endmodule

/* rtl/core/banded_lu_solver_top.sv */
// Top level of the banded LU solver: stream ports, register port, controller and ALU.
`timescale 1ns / 1ps
// Banded LU solver. Load matrix entries (tuser=0) and vector entries (tuser=1); tlast on a
// vector entry starts the run. Each load item is taken only while the block is idle.
// A new matrix is factored in place with partial pivoting inside the band, then forward and
// back substitution yield n results in index order, or one singular result. All arithmetic
// goes through one shared ALU: an add or subtract result is registered on issue, a multiply
// result passes a product register first, and a divide runs a shift-subtract loop over
// VALUE_BITS+FRAC_BITS quotient bits. Factoring swaps full rows when the pivot row differs
// and does n reciprocal divides; substitution does n divides.
// One run at a time; input is not taken during a run or while a result waits.
module banded_lu_solver_top #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [((8+VALUE_BITS+7)/8)*8-1:0] s_axis_tdata, // row_index, col_index, entry_value
  input  logic        s_axis_tuser,  // func
  input  logic        s_axis_tlast,  // load_done
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((4+VALUE_BITS+7)/8)*8-1:0] m_axis_tdata, // solution_index, solution_value
  output logic        m_axis_tuser,  // solve_status
  output logic        m_axis_tlast,  // last_result
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import blu_pkg::*;

  localparam int unsigned OutW = ((4+VALUE_BITS+7)/8)*8;

  logic [4:0] msize_q, bw_q;
  logic cfg_wr;
  alu_cmd_t cmd;
  alu_sts_t sts;
  logic signed [VALUE_BITS-1:0] aa, ab, res, oval;
  logic [3:0] oidx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msize_q <= 5'd16; bw_q <= 5'd16;
    end else if (cfg_wr) begin
      if (paddr[2] == 1'(RegMatrixSize)) msize_q <= pwdata[4:0];
      else bw_q <= pwdata[4:0];
    end
  end
  assign prdata = (paddr[2] == 1'(RegBandWidth)) ? {27'd0, bw_q} : {27'd0, msize_q};

  blu_alu #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i, .rst_ni, .cmd_i(cmd), .a_i(aa), .b_i(ab), .res_o(res), .sts_o(sts));

  blu_ctrl #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
    .in_func_i(s_axis_tuser), .in_row_i(s_axis_tdata[3:0]), .in_col_i(s_axis_tdata[7:4]),
    .in_val_i(s_axis_tdata[8 +: VALUE_BITS]), .in_done_i(s_axis_tlast),
    .matrix_size_i(msize_q), .band_width_i(bw_q), .cfg_wr_i(cfg_wr),
    .m_axis_tvalid, .m_axis_tready, .out_idx_o(oidx), .out_val_o(oval),
    .out_stat_o(m_axis_tuser), .out_last_o(m_axis_tlast),
    .alu_cmd_o(cmd), .alu_a_o(aa), .alu_b_o(ab), .alu_res_i(res), .alu_sts_i(sts));

  assign m_axis_tdata = OutW'({oval, oidx});

endmodule
